[hw/rtl/julia_escape_time_pixel_assert.svh]
// assertion macros for the julia escape-time pixel block
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk outside reset
`define JET_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jet assertion failed");
// next-cycle implication, checked on clk outside reset
`define JET_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jet assertion failed");
`else
`define JET_ASSERT_IMP(lbl, ante, cons)
`define JET_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/jet_pkg.sv]
// shared types and constants for the julia escape-time pixel block
package jet_pkg;

    localparam int COORD_W   = 9;
    localparam int CNT_W     = 8;
    localparam int C_W       = 30;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 64;
    localparam int WIDE_W    = 40;
    localparam int Q_FRAC    = 26;
    localparam int MAP_SHIFT = Q_FRAC + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [CNT_W-1:0] MAX_ITER_RST  = 8'd100;
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd10;

    // four in q12.52
    localparam logic [PROD_W-1:0] MAG_LIMIT = 64'd4 << (2 * Q_FRAC);

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_RR,
        S_II,
        S_CHK,
        S_UPD,
        S_DONE
    } jet_state_t;

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
        logic [CNT_W-1:0]      max_iter;
        logic [CNT_W-1:0]      threshold;
    } jet_cfg_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] re;
        logic signed [Q_W-1:0] im;
    } jet_map_stat_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } jet_core_ctl_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] count;
        logic             painted;
    } jet_core_stat_t;

endpackage

[hw/rtl/jet_in_if.sv]
// pixel coordinate channel
interface jet_in_if;
    import jet_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[hw/rtl/jet_out_if.sv]
// escape-time result channel
interface jet_out_if;
    import jet_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [CNT_W-1:0]   iteration_count;
    logic               painted;

    modport source (output valid, output out_x, output out_y, output iteration_count,
                    output painted, input ready);
    modport sink   (input valid, input out_x, input out_y, input iteration_count,
                    input painted, output ready);
endinterface

[hw/rtl/jet_map.sv]
// pixel to start point mapping, reciprocal multiply on both axes
module jet_map
    import jet_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    output jet_map_stat_t      stat
);

    localparam int HALF_W   = IMAGE_WIDTH / 2;
    localparam int HALF_H   = IMAGE_HEIGHT / 2;
    localparam int PIX_MAX  = (1 << COORD_W) - 1;
    localparam int HALF_MAX = (HALF_W > HALF_H) ? HALF_W : HALF_H;
    localparam int MAG_MAX  = (HALF_MAX > PIX_MAX) ? HALF_MAX : PIX_MAX;
    localparam int OM_W     = $clog2(MAG_MAX + 1);
    localparam int OFS_W    = OM_W + 1;
    localparam int LANES    = 2;

    // floor(a * 2^28 / d) = (a * m) >> sh, sh = OM_W + clog2(d), m = ceil(2^(28 + sh) / d)
    localparam int SH_X     = OM_W + $clog2(IMAGE_WIDTH);
    localparam int SH_Y     = OM_W + $clog2(IMAGE_HEIGHT);
    localparam int RCP_W    = MAP_SHIFT + OM_W + 1;
    localparam int PRD_W    = OM_W + RCP_W;

    localparam longint RCP_X = ((longint'(1) << (MAP_SHIFT + SH_X)) + longint'(IMAGE_WIDTH)
                               - longint'(1)) / longint'(IMAGE_WIDTH);
    localparam longint RCP_Y = ((longint'(1) << (MAP_SHIFT + SH_Y)) + longint'(IMAGE_HEIGHT)
                               - longint'(1)) / longint'(IMAGE_HEIGHT);

    localparam logic signed [OFS_W-1:0] HALF_X_S = OFS_W'(HALF_W);
    localparam logic signed [OFS_W-1:0] HALF_Y_S = OFS_W'(HALF_H);
    localparam logic [RCP_W-1:0] RCP [LANES] = '{RCP_W'(RCP_X), RCP_W'(RCP_Y)};
    localparam int               SH  [LANES] = '{SH_X, SH_Y};

    logic              stage_reg;
    logic              done_reg;
    logic [OM_W-1:0]   mag_reg  [LANES];
    logic              neg_reg  [LANES];
    logic [PRD_W-1:0]  prod_reg [LANES];

    logic signed [OFS_W-1:0] ofs       [LANES];
    logic signed [OFS_W-1:0] ofs_abs   [LANES];
    logic [PRD_W-1:0]        prod_next [LANES];
    logic [PRD_W-1:0]        quo       [LANES];
    logic                    ovf       [LANES];
    logic signed [Q_W-1:0]   val       [LANES];

    always_comb
    begin
        ofs[0] = $signed({{(OFS_W-COORD_W){1'b0}}, pixel_x}) - HALF_X_S;
        ofs[1] = HALF_Y_S - $signed({{(OFS_W-COORD_W){1'b0}}, pixel_y});
        for (int l = 0; l < LANES; l++)
        begin
            ofs_abs[l]   = ofs[l][OFS_W-1] ? -ofs[l] : ofs[l];
            prod_next[l] = PRD_W'(mag_reg[l]) * PRD_W'(RCP[l]);
            quo[l]       = prod_reg[l] >> SH[l];
            // quotient at or above 2^31 saturates either way
            ovf[l]       = |quo[l][PRD_W-1:Q_W-1];
            if (neg_reg[l])
            begin
                val[l] = ovf[l] ? Q_MIN : $signed(-quo[l][Q_W-1:0]);
            end
            else
            begin
                val[l] = ovf[l] ? Q_MAX : $signed(quo[l][Q_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (start)
            begin
                mag_reg[l] <= ofs_abs[l][OM_W-1:0];
                neg_reg[l] <= ofs[l][OFS_W-1];
            end
            if (stage_reg)
            begin
                prod_reg[l] <= prod_next[l];
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.re   = val[0];
    assign stat.im   = val[1];

endmodule

[hw/rtl/jet_core.sv]
// iteration sequencer around one shared 32x32 multiplier
module jet_core
    import jet_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  jet_core_ctl_t  ctl,
    input  jet_map_stat_t  map_stat,
    input  jet_cfg_t       cfg,
    output jet_core_stat_t stat
);
`include "julia_escape_time_pixel_assert.svh"

    localparam int SQ_EXT = WIDE_W - (PROD_W - Q_FRAC);
    localparam int CR_EXT = WIDE_W - (PROD_W - Q_FRAC + 1);
    localparam int C_EXT  = WIDE_W - C_W;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[WIDE_W-1:Q_W-1];
        all_zeros = ~|v[WIDE_W-1:Q_W-1];
        if (all_ones || all_zeros)
        begin
            sat_q = v[Q_W-1:0];
        end
        else
        begin
            sat_q = v[WIDE_W-1] ? Q_MIN : Q_MAX;
        end
    endfunction

    jet_state_t state_reg;
    jet_state_t state_next;

    logic signed [Q_W-1:0]    re_reg;
    logic signed [Q_W-1:0]    im_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] sq_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     escaped_reg;

    logic signed [Q_W-1:0]    mul_a;
    logic signed [Q_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        mag_sum;
    logic                     mag_gt;
    logic                     stop;
    logic signed [WIDE_W-1:0] re_diff;
    logic signed [WIDE_W-1:0] im_diff;

    // |z|^2 of the current point, valid in the check state
    assign mag_sum = rr_reg + prod_reg;
    assign mag_gt  = (mag_sum > MAG_LIMIT);
    assign stop    = (count_reg != '0) && ((count_reg >= cfg.max_iter) || mag_gt);

    // floor shifts are arithmetic shifts of the exact products
    assign re_diff = {{SQ_EXT{sq_reg[PROD_W-1]}}, sq_reg[PROD_W-1:Q_FRAC]}
                   - {{C_EXT{cfg.c_real[C_W-1]}}, cfg.c_real};
    assign im_diff = {{CR_EXT{prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:Q_FRAC-1]}
                   - {{C_EXT{cfg.c_imag[C_W-1]}}, cfg.c_imag};

    assign prod_next = $signed({{(PROD_W-Q_W){mul_a[Q_W-1]}}, mul_a})
                     * $signed({{(PROD_W-Q_W){mul_b[Q_W-1]}}, mul_b});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (ctl.start) state_next = S_MAP;
            S_MAP:  if (map_stat.done) state_next = S_RR;
            S_RR:   state_next = S_II;
            S_II:   state_next = S_CHK;
            S_CHK:  state_next = stop ? S_DONE : S_UPD;
            S_UPD:  state_next = S_RR;
            S_DONE: if (ctl.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a        = re_reg;
        mul_b        = im_reg;
        stat.idle    = 1'b0;
        stat.done    = 1'b0;
        stat.count   = count_reg;
        stat.painted = (count_reg > cfg.threshold) && !escaped_reg;
        unique case (state_reg)
            S_IDLE: stat.idle = 1'b1;
            S_RR:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
            S_II:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            S_DONE: stat.done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && ctl.start)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_UPD)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (state_reg == S_MAP && map_stat.done)
        begin
            re_reg <= map_stat.re;
            im_reg <= map_stat.im;
        end
        if (state_reg == S_II)
        begin
            rr_reg <= prod_reg;
        end
        if (state_reg == S_CHK)
        begin
            sq_reg      <= rr_reg - prod_reg;
            escaped_reg <= mag_gt;
        end
        if (state_reg == S_UPD)
        begin
            re_reg <= sat_q(re_diff);
            im_reg <= sat_q(im_diff);
        end
    end

    `JET_ASSERT_IMP(a_map_done_in_map, map_stat.done, state_reg == S_MAP)
    `JET_ASSERT_NXT(a_upd_counts, state_reg == S_UPD, state_reg == S_RR && count_reg != '0)
    `JET_ASSERT_IMP(a_done_has_count, state_reg == S_DONE, count_reg != '0)

endmodule

[hw/rtl/julia_escape_time_pixel.sv]
// julia escape-time evaluator for one pixel, top level
//
//  channel   dir   handshake       word
//  --------  ----  --------------  ----------------------------------------
//  pixel     in    valid / ready   pixel_x, pixel_y
//  result    out   valid / ready   out_x, out_y, iteration_count, painted
//  cfg_*     in    write enable    register index and data, no read-back
//
// one pixel at a time; the map registers the pixel offset, then a
// reciprocal multiply per axis; each iteration runs on the shared 32x32
// multiplier (re*re, im*im, re*im with the escape check, update); after
// the last escape check the word is handed to the output once that slot
// is free, and then the sequencer goes back to idle
// reset clears the sequencer, the output valid and loads register defaults
// a finished word sits in the output register; the next pixel is taken as
// soon as that word is parked there, even while result ready is low
module julia_escape_time_pixel
    import jet_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    jet_in_if.sink               pixel,
    jet_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [C_W-1:0]       cfg_data
);

    // configuration registers
    logic signed [C_W-1:0] c_real_reg;
    logic signed [C_W-1:0] c_imag_reg;
    logic [CNT_W-1:0]      max_iter_reg;
    logic [CNT_W-1:0]      threshold_reg;

    // pixel held for the echo
    logic [COORD_W-1:0] pix_x_reg;
    logic [COORD_W-1:0] pix_y_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_painted_reg;

    logic           accept;
    logic           out_free;
    jet_cfg_t       cfg;
    jet_map_stat_t  map_stat;
    jet_core_ctl_t  core_ctl;
    jet_core_stat_t core_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg    <= '0;
            c_imag_reg    <= '0;
            max_iter_reg  <= MAX_ITER_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_C_REAL:    c_real_reg    <= cfg_data;
                CFG_C_IMAG:    c_imag_reg    <= cfg_data;
                CFG_MAX_ITER:  max_iter_reg  <= cfg_data[CNT_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.c_real    = c_real_reg;
    assign cfg.c_imag    = c_imag_reg;
    assign cfg.max_iter  = max_iter_reg;
    assign cfg.threshold = threshold_reg;

    // the sequencer takes a pixel only when it is back in idle
    assign pixel.ready = core_stat.idle;
    assign accept      = pixel.valid & pixel.ready;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || result.ready;

    assign core_ctl.start    = accept;
    assign core_ctl.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_x_reg <= pixel.pixel_x;
            pix_y_reg <= pixel.pixel_y;
        end
    end

    jet_map #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .pixel_x (pixel.pixel_x),
        .pixel_y (pixel.pixel_y),
        .stat    (map_stat)
    );

    jet_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (core_ctl),
        .map_stat (map_stat),
        .cfg      (cfg),
        .stat     (core_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_stat.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_stat.done && out_free)
        begin
            out_x_reg       <= pix_x_reg;
            out_y_reg       <= pix_y_reg;
            out_count_reg   <= core_stat.count;
            out_painted_reg <= core_stat.painted;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.out_x           = out_x_reg;
    assign result.out_y           = out_y_reg;
    assign result.iteration_count = out_count_reg;
    assign result.painted         = out_painted_reg;

endmodule
